// ===== sv/square_wave_channel_defines.svh =====
// Assertion macros for the square wave channel.
`ifndef SQUARE_WAVE_CHANNEL_DEFINES_SVH
`define SQUARE_WAVE_CHANNEL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define SWC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("square_wave_channel: assertion failed");

// Checked at every clock edge, reset included.
`define SWC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("square_wave_channel: assertion failed");

`else

`define SWC_ASSERT(label, prop)
`define SWC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== sv/swc_pkg.sv =====
// Package for the square wave channel: request/response types, codes, tables.
package swc_pkg;

   // request kinds
   localparam logic [2:0] KIND_WRITE    = 3'd0;
   localparam logic [2:0] KIND_READ     = 3'd1;
   localparam logic [2:0] KIND_TICK     = 3'd2;
   localparam logic [2:0] KIND_LENGTH   = 3'd3;
   localparam logic [2:0] KIND_ENVELOPE = 3'd4;

   // register indexes
   localparam logic [1:0] REG_DUTY_LEN  = 2'd0;
   localparam logic [1:0] REG_ENVELOPE  = 2'd1;
   localparam logic [1:0] REG_FREQ_LO   = 2'd2;
   localparam logic [1:0] REG_FREQ_HI   = 2'd3;

   localparam logic [6:0]  LENGTH_FULL  = 7'd64;
   localparam logic [15:0] TIMER_MIN    = 16'h8000;
   localparam logic [7:0]  RD_DUTY_MASK = 8'h3f;
   localparam logic [7:0]  RD_FREQ_LO   = 8'hff;
   localparam logic [7:0]  RD_CTRL_MASK = 8'hbf;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] tick_cycles;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       channel_on;
      logic [3:0] sample;
   } rsp_type;

   // timer reload: (2048 - freq) * 4, range 4..8192
   function automatic logic [13:0] reload_period(input logic [10:0] freq);
      logic [11:0] span;
      begin
         span = 12'h800 - {1'b0, freq};
         reload_period = {span, 2'b00};
      end
   endfunction

   // waveform bit of the selected duty at a wave position
   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] pattern;
      begin
         case (sel)
            2'd0: pattern = 8'b1000_0000;
            2'd1: pattern = 8'b1000_0001;
            2'd2: pattern = 8'b1110_0001;
            default: pattern = 8'b0111_1110;
         endcase
         duty_bit = pattern[pos];
      end
   endfunction

endpackage

// ===== sv/square_wave_channel.sv =====
// Square wave channel top level: request register, channel state, response register.
// Square wave sound channel with duty/length, envelope, frequency-low and
// frequency-high/control registers, driven by one request stream: register
// write, register read, timer tick of tick_cycles cycles, length clock or
// envelope clock. Every request yields exactly one response carrying the read
// data (zero for non-read requests), the on flag and the current sample. A
// request is held in an input register, from which its state update and
// response are computed and registered, so one request per clock is sustained as
// long as rsp_ready is high whenever a response is waiting.
// While a response waits, at most one more request is taken (into an empty
// input register) and req_ready then stays low until the response is taken;
// rsp_ready reaches req_ready through logic only.
// Synchronous active-high reset clears all channel state.
`include "square_wave_channel_defines.svh"

module square_wave_channel (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  swc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output swc_pkg::rsp_type rsp_data
);

   // request stage
   logic             req_vld_ff;
   swc_pkg::req_type req_ff;
   // response stage
   logic             rsp_vld_ff;
   swc_pkg::rsp_type rsp_ff;
   swc_pkg::rsp_type rsp_in;

   // channel state
   logic [1:0]  duty_ff,      duty_in;
   logic [2:0]  wave_pos_ff,  wave_pos_in;
   logic        len_en_ff,    len_en_in;
   logic [6:0]  len_cnt_ff,   len_cnt_in;
   logic [10:0] freq_ff,      freq_in;
   logic        enabled_ff,   enabled_in;
   logic [15:0] timer_ff,     timer_in;
   logic [3:0]  volume_ff,    volume_in;
   logic        vol_rise_ff,  vol_rise_in;
   logic [2:0]  env_per_ff,   env_per_in;
   logic [3:0]  env_cnt_ff,   env_cnt_in;

   logic        advance;
   logic        fire;

   logic [16:0] tick_diff;
   logic [15:0] tick_sat;
   logic [13:0] tick_reload;
   logic [10:0] wr_freq;
   logic [3:0]  env_dec;
   logic [7:0]  rd_data;

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign fire      = req_vld_ff && advance;
   assign req_ready = !req_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      duty_in     = duty_ff;
      wave_pos_in = wave_pos_ff;
      len_en_in   = len_en_ff;
      len_cnt_in  = len_cnt_ff;
      freq_in     = freq_ff;
      enabled_in  = enabled_ff;
      timer_in    = timer_ff;
      volume_in   = volume_ff;
      vol_rise_in = vol_rise_ff;
      env_per_in  = env_per_ff;
      env_cnt_in  = env_cnt_ff;
      rd_data     = 8'h00;

      // tick path: subtract, saturate at the signed floor, reload once
      tick_diff   = {timer_ff[15], timer_ff} - {9'b0, req_ff.tick_cycles};
      tick_sat    = (tick_diff[16] && !tick_diff[15]) ? swc_pkg::TIMER_MIN
                                                      : tick_diff[15:0];
      tick_reload = swc_pkg::reload_period(freq_ff);
      env_dec     = env_cnt_ff - 4'd1;

      wr_freq = freq_ff;
      case (req_ff.reg_index)
         swc_pkg::REG_FREQ_LO: wr_freq = {freq_ff[10:8], req_ff.write_data};
         swc_pkg::REG_FREQ_HI: wr_freq = {req_ff.write_data[2:0], freq_ff[7:0]};
         default:              wr_freq = freq_ff;
      endcase

      case (req_ff.kind)
         swc_pkg::KIND_WRITE: begin
            case (req_ff.reg_index)
               swc_pkg::REG_DUTY_LEN: begin
                  duty_in    = req_ff.write_data[7:6];
                  len_cnt_in = swc_pkg::LENGTH_FULL - {1'b0, req_ff.write_data[5:0]};
               end
               swc_pkg::REG_ENVELOPE: begin
                  volume_in   = req_ff.write_data[7:4];
                  vol_rise_in = req_ff.write_data[3];
                  env_per_in  = req_ff.write_data[2:0];
                  env_cnt_in  = {1'b0, req_ff.write_data[2:0]};
               end
               swc_pkg::REG_FREQ_LO: begin
                  freq_in  = wr_freq;
                  timer_in = {2'b00, swc_pkg::reload_period(wr_freq)};
               end
               default: begin
                  enabled_in  = req_ff.write_data[7];
                  len_en_in   = req_ff.write_data[6];
                  freq_in     = wr_freq;
                  timer_in    = {2'b00, swc_pkg::reload_period(wr_freq)};
                  wave_pos_in = 3'd0;
                  if (req_ff.write_data[7] && len_cnt_ff == 7'd0) begin
                     len_cnt_in = swc_pkg::LENGTH_FULL;
                  end
               end
            endcase
         end
         swc_pkg::KIND_READ: begin
            case (req_ff.reg_index)
               swc_pkg::REG_DUTY_LEN: rd_data = {duty_ff, 6'b0} | swc_pkg::RD_DUTY_MASK;
               swc_pkg::REG_ENVELOPE: rd_data = {volume_ff, vol_rise_ff, env_per_ff};
               swc_pkg::REG_FREQ_LO:  rd_data = swc_pkg::RD_FREQ_LO;
               default:               rd_data = {1'b0, len_en_ff, 6'b0}
                                                | swc_pkg::RD_CTRL_MASK;
            endcase
         end
         swc_pkg::KIND_TICK: begin
            if (tick_sat[15] || tick_sat == 16'd0) begin
               timer_in    = tick_sat + {2'b00, tick_reload};
               wave_pos_in = wave_pos_ff + 3'd1;
            end else begin
               timer_in = tick_sat;
            end
         end
         swc_pkg::KIND_LENGTH: begin
            if (len_en_ff && len_cnt_ff != 7'd0) begin
               len_cnt_in = len_cnt_ff - 7'd1;
               if (len_cnt_ff == 7'd1) begin
                  enabled_in = 1'b0;
               end
            end
         end
         swc_pkg::KIND_ENVELOPE: begin
            if (env_per_ff != 3'd0) begin
               env_cnt_in = env_dec;
               if (env_dec[3] || env_dec == 4'd0) begin
                  env_cnt_in = {1'b0, env_per_ff};
                  if (vol_rise_ff) begin
                     if (volume_ff != 4'hf) begin
                        volume_in = volume_ff + 4'd1;
                     end
                  end else if (volume_ff != 4'h0) begin
                     volume_in = volume_ff - 4'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.read_data  = rd_data;
      rsp_in.channel_on = enabled_in;
      rsp_in.sample     = (enabled_in && swc_pkg::duty_bit(duty_in, wave_pos_in))
                          ? volume_in : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         duty_ff     <= '0;
         wave_pos_ff <= '0;
         len_en_ff   <= 1'b0;
         len_cnt_ff  <= '0;
         freq_ff     <= '0;
         enabled_ff  <= 1'b0;
         timer_ff    <= '0;
         volume_ff   <= '0;
         vol_rise_ff <= 1'b0;
         env_per_ff  <= '0;
         env_cnt_ff  <= '0;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (fire) begin
            duty_ff     <= duty_in;
            wave_pos_ff <= wave_pos_in;
            len_en_ff   <= len_en_in;
            len_cnt_ff  <= len_cnt_in;
            freq_ff     <= freq_in;
            enabled_ff  <= enabled_in;
            timer_ff    <= timer_in;
            volume_ff   <= volume_in;
            vol_rise_ff <= vol_rise_in;
            env_per_ff  <= env_per_in;
            env_cnt_ff  <= env_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // length counter never loads past a full count
   `SWC_ASSERT(len_cnt_range_a, len_cnt_ff <= swc_pkg::LENGTH_FULL)
   // an enabled channel always has length left
   `SWC_ASSERT(enabled_has_len_a, enabled_ff |-> len_cnt_ff != 7'd0)
   // envelope count stays within the loaded period
   `SWC_ASSERT(env_cnt_range_a, !env_cnt_ff[3] && env_cnt_ff[2:0] <= env_per_ff)
   // a sounding sample implies the channel is on
   `SWC_ASSERT(sample_needs_on_a, (rsp_vld_ff && rsp_ff.sample != 4'd0) |-> rsp_ff.channel_on)

endmodule
